>>> rtl/core/rotation_matrix_to_quaternion_macros.svh
// Assertion macros shared by the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is applied.
`define RMQ_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rmq_pkg.sv
// Shared widths, types and helper functions for the matrix to quaternion pipeline.
package rmq_pkg;

  // Fraction bits of the fixed-point entries and results.
  localparam int FRAC_BITS = 30;

  localparam int ENTRY_W = 32;
  localparam int TOL_W   = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

  // A floored product of two entries needs two bits above the entry width.
  localparam int PROD_W = 2 * ENTRY_W - FRAC_BITS + 2;

  // Magnitudes after the pre-shift, and the sum of their squares.
  localparam int MAG_W  = 31;
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  // Quotient and numerator of the normalising divide.
  localparam int QUOT_W = FRAC_BITS + 1;
  localparam int NUM_W  = MAG_W + FRAC_BITS + 1;

  localparam int CHECK_STAGES = 6;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = QUOT_W;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  // One quaternion component on its way to the divider: sign and magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_t;

  // Control and payload that travel beside the square root and the divide.
  typedef struct packed {
    logic            valid;
    logic            ok;
    lane_t [3:0]     lane;
  } tag_t;

  // Exact product of two entries, floored to the fraction bits.
  function automatic logic signed [PROD_W-1:0] fmul(input entry_t a, input entry_t b);
    logic signed [2*ENTRY_W-1:0] p;
    p = a * b;
    return PROD_W'(p >>> FRAC_BITS);
  endfunction

endpackage

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion converter, top level.
//
// Accepts one 3x3 matrix in signed Q2.30 every clock cycle while item_stall is low, and
// returns its unit quaternion: six stages of orthonormality and determinant checking run
// beside the case selection and sum of squares, a 32-stage square root follows, then a
// 32-stage four-lane divider and one output register. A matrix that fails the check gives
// valid_res low and a zero quaternion. The whole pipeline advances together, so while a
// result is held by res_stall the input stalls as well; bubbles are passed on unchanged.
// The tolerance register is written through the cfg channel, which is always ready, and
// should only be changed while no matrix is in flight.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic signed [ENTRY_W-1:0] m00,
  input  logic signed [ENTRY_W-1:0] m01,
  input  logic signed [ENTRY_W-1:0] m02,
  input  logic signed [ENTRY_W-1:0] m10,
  input  logic signed [ENTRY_W-1:0] m11,
  input  logic signed [ENTRY_W-1:0] m12,
  input  logic signed [ENTRY_W-1:0] m20,
  input  logic signed [ENTRY_W-1:0] m21,
  input  logic signed [ENTRY_W-1:0] m22,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [QUOT_W-1:0]         quat_w,
  output logic signed [ENTRY_W-1:0] quat_x,
  output logic signed [ENTRY_W-1:0] quat_y,
  output logic signed [ENTRY_W-1:0] quat_z,
  output logic                      valid_res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TOL_W-1:0]          cfg_data
);

  localparam logic [QUOT_W-1:0] ONE_W = QUOT_W'(1) << FRAC_BITS;

  logic              en;
  logic [TOL_W-1:0]  tolerance;
  entry_t            mat [3][3];

  logic              chk_valid;
  logic              chk_ok;
  lane_t [3:0]       shep_lanes;
  logic [SUM_W-1:0]  shep_sum;
  tag_t              chk_tag;

  tag_t              sqrt_tag;
  logic [ROOT_W-1:0] sqrt_root;

  tag_t              div_tag;
  logic [QUOT_W-1:0] div_quot [4];

  // The pipeline moves unless a finished result is being held.
  assign en         = !(res_valid && res_stall);
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  always_comb begin
    mat[0][0] = m00;
    mat[0][1] = m01;
    mat[0][2] = m02;
    mat[1][0] = m10;
    mat[1][1] = m11;
    mat[1][2] = m12;
    mat[2][0] = m20;
    mat[2][1] = m21;
    mat[2][2] = m22;
  end

  rmq_check u_check (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid),
    .mat       (mat),
    .tolerance (tolerance),
    .out_valid (chk_valid),
    .out_ok    (chk_ok)
  );

  rmq_shepperd u_shepperd (
    .clk   (clk),
    .en    (en),
    .mat   (mat),
    .lanes (shep_lanes),
    .sum   (shep_sum)
  );

  // Both front-end blocks have the same depth, so their outputs line up here.
  always_comb begin
    chk_tag.valid = chk_valid;
    chk_tag.ok    = chk_ok;
    chk_tag.lane  = shep_lanes;
  end

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_tag   (chk_tag),
    .radicand (shep_sum),
    .out_tag  (sqrt_tag),
    .root     (sqrt_root)
  );

  rmq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_tag  (sqrt_tag),
    .root    (sqrt_root),
    .out_tag (div_tag),
    .quot    (div_quot)
  );

  // Output register: apply the signs, or zero everything when the check failed.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= div_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      valid_res <= div_tag.ok;
      if (div_tag.ok) begin
        quat_w <= div_quot[0];
        quat_x <= div_tag.lane[1].neg ? -ENTRY_W'(div_quot[1]) : ENTRY_W'(div_quot[1]);
        quat_y <= div_tag.lane[2].neg ? -ENTRY_W'(div_quot[2]) : ENTRY_W'(div_quot[2]);
        quat_z <= div_tag.lane[3].neg ? -ENTRY_W'(div_quot[3]) : ENTRY_W'(div_quot[3]);
      end else begin
        quat_w <= '0;
        quat_x <= '0;
        quat_y <= '0;
        quat_z <= '0;
      end
    end
  end

  // A rejected matrix leaves no trace in the quaternion fields.
  `RMQ_ASSERT_IMP(a_fail_zero, res_valid && !valid_res, quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0, "rejected matrix gave a non-zero quaternion")
  // Rounding never lifts the scalar part above one.
  `RMQ_ASSERT_IMP(a_w_range, res_valid && valid_res, quat_w <= ONE_W, "scalar part above one")
  // Reset empties the pipeline.
  `RMQ_ASSERT_RST(a_rst_empty, !res_valid, "result presented straight after reset")

endmodule

>>> rtl/core/rmq_check.sv
// Orthonormality and determinant check, six register stages.
module rmq_check import rmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  entry_t           mat [3][3],
  input  logic [TOL_W-1:0] tolerance,
  output logic             out_valid,
  output logic             out_ok
);

  localparam int NPAIR = 3;
  localparam int PAIR_I [NPAIR] = '{0, 0, 1};
  localparam int PAIR_J [NPAIR] = '{1, 2, 2};
  localparam int NDOT   = 12;
  localparam int DOT_W  = PROD_W + 2;
  localparam int COF_W  = ENTRY_W + 1;
  localparam int TERM_W = ENTRY_W + COF_W - FRAC_BITS + 2;
  localparam int DET_W  = TERM_W + 2;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic [DOT_W:0]           dev_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [DET_W-1:0]  det_t;

  localparam logic signed [DOT_W:0]  ONE_DOT = (DOT_W + 1)'(64'd1 << FRAC_BITS);
  localparam logic signed [DET_W:0]  ONE_DET = (DET_W + 1)'(64'd1 << FRAC_BITS);
  localparam logic signed [PROD_W:0] COF_LIM = (PROD_W + 1)'(64'hFFFF_FFFF);

  // Cofactor difference clamped to plus or minus the limit.
  function automatic cof_t sat_cof(input prod_t a, input prod_t b);
    logic signed [PROD_W:0] d;
    d = (PROD_W + 1)'(a) - (PROD_W + 1)'(b);
    if (d > COF_LIM) begin
      return COF_W'(COF_LIM);
    end
    if (d < -COF_LIM) begin
      return COF_W'(-COF_LIM);
    end
    return COF_W'(d);
  endfunction

  // Distance of a dot product from one (diagonal) or zero.
  function automatic dev_t deviation(input dot_t d, input logic diag);
    logic signed [DOT_W:0] e;
    e = (DOT_W + 1)'(d) - (diag ? ONE_DOT : '0);
    return e[DOT_W] ? dev_t'(-e) : dev_t'(e);
  endfunction

  // Entry times cofactor, floored to the fraction bits.
  function automatic term_t det_term(input entry_t a, input cof_t c);
    logic signed [ENTRY_W+COF_W-1:0] p;
    p = a * c;
    return TERM_W'(p >>> FRAC_BITS);
  endfunction

  logic [CHECK_STAGES-1:0] vld;

  prod_t  sq   [3][3];
  prod_t  rowx [NPAIR][3];
  prod_t  colx [NPAIR][3];
  prod_t  cofp [6];
  entry_t row0_c1 [3];

  dot_t   dot_rd [3];
  dot_t   dot_cd [3];
  dot_t   dot_ro [NPAIR];
  dot_t   dot_co [NPAIR];
  cof_t   cof    [3];
  entry_t row0_c2 [3];

  dev_t   dv [NDOT];
  term_t  dt [3];

  logic   dot_ok_c4;
  det_t   det;

  logic   dot_ok_c5;
  logic [DET_W:0] det_dev;

  logic   ok_c6;

  // Valid bits travel beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CHECK_STAGES-2:0], in_valid};
    end
  end

  // Stage 1: all floored entry products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sq[i][j] <= fmul(mat[i][j], mat[i][j]);
        end
        row0_c1[i] <= mat[0][i];
      end
      for (int p = 0; p < NPAIR; p++) begin
        for (int k = 0; k < 3; k++) begin
          rowx[p][k] <= fmul(mat[PAIR_I[p]][k], mat[PAIR_J[p]][k]);
          colx[p][k] <= fmul(mat[k][PAIR_I[p]], mat[k][PAIR_J[p]]);
        end
      end
      cofp[0] <= fmul(mat[1][1], mat[2][2]);
      cofp[1] <= fmul(mat[1][2], mat[2][1]);
      cofp[2] <= fmul(mat[1][0], mat[2][2]);
      cofp[3] <= fmul(mat[1][2], mat[2][0]);
      cofp[4] <= fmul(mat[1][0], mat[2][1]);
      cofp[5] <= fmul(mat[1][1], mat[2][0]);
    end
  end

  // Stage 2: dot product sums and clamped cofactors.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dot_rd[i] <= DOT_W'(sq[i][0]) + DOT_W'(sq[i][1]) + DOT_W'(sq[i][2]);
        dot_cd[i] <= DOT_W'(sq[0][i]) + DOT_W'(sq[1][i]) + DOT_W'(sq[2][i]);
        row0_c2[i] <= row0_c1[i];
      end
      for (int p = 0; p < NPAIR; p++) begin
        dot_ro[p] <= DOT_W'(rowx[p][0]) + DOT_W'(rowx[p][1]) + DOT_W'(rowx[p][2]);
        dot_co[p] <= DOT_W'(colx[p][0]) + DOT_W'(colx[p][1]) + DOT_W'(colx[p][2]);
      end
      cof[0] <= sat_cof(cofp[0], cofp[1]);
      cof[1] <= sat_cof(cofp[2], cofp[3]);
      cof[2] <= sat_cof(cofp[4], cofp[5]);
    end
  end

  // Stage 3: distances of the dot products and the determinant terms.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv[i]     <= deviation(dot_rd[i], 1'b1);
        dv[i + 3] <= deviation(dot_cd[i], 1'b1);
        dv[i + 6] <= deviation(dot_ro[i], 1'b0);
        dv[i + 9] <= deviation(dot_co[i], 1'b0);
        dt[i]     <= det_term(row0_c2[i], cof[i]);
      end
    end
  end

  // Stage 4: dot product verdict and the determinant sum.
  always_ff @(posedge clk) begin
    logic all_ok;
    all_ok = 1'b1;
    for (int i = 0; i < NDOT; i++) begin
      if (dv[i] > (DOT_W + 1)'(tolerance)) begin
        all_ok = 1'b0;
      end
    end
    if (en) begin
      dot_ok_c4 <= all_ok;
      det <= DET_W'(dt[0]) - DET_W'(dt[1]) + DET_W'(dt[2]);
    end
  end

  // Stage 5: distance of the determinant from one.
  always_ff @(posedge clk) begin
    logic signed [DET_W:0] e;
    e = (DET_W + 1)'(det) - ONE_DET;
    if (en) begin
      dot_ok_c5 <= dot_ok_c4;
      det_dev   <= e[DET_W] ? (DET_W + 1)'(-e) : (DET_W + 1)'(e);
    end
  end

  // Stage 6: overall verdict.
  always_ff @(posedge clk) begin
    if (en) begin
      ok_c6 <= dot_ok_c5 && (det_dev <= (DET_W + 1)'(tolerance));
    end
  end

  assign out_valid = vld[CHECK_STAGES-1];
  assign out_ok    = ok_c6;

endmodule

>>> rtl/core/rmq_shepperd.sv
// Case selection, scaled quaternion, pre-shift and sum of squares, six register stages.
module rmq_shepperd import rmq_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  entry_t           mat [3][3],
  output lane_t [3:0]      lanes,
  output logic [SUM_W-1:0] sum
);

  localparam int TR_W   = ENTRY_W + 2;
  localparam int U_W    = ENTRY_W + 3;
  localparam int SH_MAX = U_W - MAG_W;
  localparam int SH_W   = $clog2(SH_MAX + 1);

  localparam logic signed [U_W-1:0] ONE_U = U_W'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    CASE_TRACE,
    CASE_X,
    CASE_Y,
    CASE_Z
  } sel_t;

  typedef logic signed [U_W-1:0] u_t;

  function automatic u_t ext(input entry_t e);
    return U_W'(e);
  endfunction

  entry_t m1 [3][3];
  sel_t   sel;

  u_t     u [4];

  logic [U_W-1:0] absu [4];
  logic           neg3 [4];

  lane_t [3:0]    lanes4;
  lane_t [3:0]    lanes5;
  lane_t [3:0]    lanes6;
  logic [2*MAG_W-1:0] sqv [4];
  logic [SUM_W-1:0]   sum6;

  logic signed [TR_W-1:0] tr;
  logic [U_W-1:0]         orv;
  logic [SH_W-1:0]        sh;

  // Stage 1: trace and the choice of case.
  assign tr = TR_W'(mat[0][0]) + TR_W'(mat[1][1]) + TR_W'(mat[2][2]);

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= mat;
      if (!tr[TR_W-1] && tr != '0) begin
        sel <= CASE_TRACE;
      end else if (mat[0][0] > mat[1][1] && mat[0][0] > mat[2][2]) begin
        sel <= CASE_X;
      end else if (mat[1][1] > mat[2][2]) begin
        sel <= CASE_Y;
      end else begin
        sel <= CASE_Z;
      end
    end
  end

  // Stage 2: quaternion scaled by four times the chosen component.
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (sel)
        CASE_TRACE: begin
          u[0] <= ext(m1[0][0]) + ext(m1[1][1]) + ext(m1[2][2]) + ONE_U;
          u[1] <= ext(m1[2][1]) - ext(m1[1][2]);
          u[2] <= ext(m1[0][2]) - ext(m1[2][0]);
          u[3] <= ext(m1[1][0]) - ext(m1[0][1]);
        end
        CASE_X: begin
          u[0] <= ext(m1[2][1]) - ext(m1[1][2]);
          u[1] <= ONE_U + ext(m1[0][0]) - ext(m1[1][1]) - ext(m1[2][2]);
          u[2] <= ext(m1[0][1]) + ext(m1[1][0]);
          u[3] <= ext(m1[0][2]) + ext(m1[2][0]);
        end
        CASE_Y: begin
          u[0] <= ext(m1[0][2]) - ext(m1[2][0]);
          u[1] <= ext(m1[0][1]) + ext(m1[1][0]);
          u[2] <= ONE_U + ext(m1[1][1]) - ext(m1[0][0]) - ext(m1[2][2]);
          u[3] <= ext(m1[1][2]) + ext(m1[2][1]);
        end
        CASE_Z: begin
          u[0] <= ext(m1[1][0]) - ext(m1[0][1]);
          u[1] <= ext(m1[0][2]) + ext(m1[2][0]);
          u[2] <= ext(m1[1][2]) + ext(m1[2][1]);
          u[3] <= ONE_U + ext(m1[2][2]) - ext(m1[0][0]) - ext(m1[1][1]);
        end
        default: begin
          for (int i = 0; i < 4; i++) begin
            u[i] <= '0;
          end
        end
      endcase
    end
  end

  // Stage 3: magnitudes, and signs flipped when the scalar part is negative.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        absu[i] <= u[i][U_W-1] ? U_W'(-u[i]) : U_W'(u[i]);
        neg3[i] <= u[i][U_W-1] ^ u[0][U_W-1];
      end
    end
  end

  // Stage 4: shift every magnitude until the largest fits the lane width.
  always_comb begin
    orv = absu[0] | absu[1] | absu[2] | absu[3];
    sh  = '0;
    for (int k = 1; k <= SH_MAX; k++) begin
      if (orv[MAG_W+k-1]) begin
        sh = SH_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        lanes4[i].neg <= neg3[i];
        lanes4[i].mag <= MAG_W'(absu[i] >> sh);
      end
    end
  end

  // Stage 5: squares of the magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      lanes5 <= lanes4;
      for (int i = 0; i < 4; i++) begin
        sqv[i] <= lanes4[i].mag * lanes4[i].mag;
      end
    end
  end

  // Stage 6: sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      lanes6 <= lanes5;
      sum6   <= SUM_W'(sqv[0]) + SUM_W'(sqv[1]) + SUM_W'(sqv[2]) + SUM_W'(sqv[3]);
    end
  end

  assign lanes = lanes6;
  assign sum   = sum6;

endmodule

>>> rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module rmq_sqrt import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tag_t              in_tag,
  input  logic [SUM_W-1:0]  radicand,
  output tag_t              out_tag,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  typedef struct packed {
    tag_t              tag;
    logic [SUM_W-1:0]  x;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sq_stage_t;

  // One digit step: bring down two radicand bits and try the next root bit.
  function automatic sq_stage_t sqrt_step(input sq_stage_t s);
    sq_stage_t        n;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    n      = s;
    rem_sh = {s.rem, s.x[SUM_W-1 -: 2]};
    trial  = (REM_W + 2)'({s.root, 2'b01});
    if (rem_sh >= trial) begin
      n.rem  = REM_W'(rem_sh - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = REM_W'(rem_sh);
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    n.x = s.x << 2;
    return n;
  endfunction

  sq_stage_t first;
  sq_stage_t nxt [SQRT_STAGES];
  sq_stage_t st  [SQRT_STAGES];

  always_comb begin
    first.tag  = in_tag;
    first.x    = radicand;
    first.root = '0;
    first.rem  = '0;
    nxt[0]     = sqrt_step(first);
    for (int s = 1; s < SQRT_STAGES; s++) begin
      nxt[s] = sqrt_step(st[s-1]);
    end
  end

  // The whole stage array advances together; reset clears only the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        st[s].tag.valid <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        st[s] <= nxt[s];
      end
    end
  end

  assign out_tag = st[SQRT_STAGES-1].tag;
  assign root    = st[SQRT_STAGES-1].root;

endmodule

>>> rtl/core/rmq_div.sv
// Pipelined four-lane restoring divider that normalises the quaternion by the root.
module rmq_div import rmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tag_t              in_tag,
  input  logic [ROOT_W-1:0] root,
  output tag_t              out_tag,
  output logic [QUOT_W-1:0] quot [4]
);

  typedef struct packed {
    logic [QUOT_W-1:0] low;
    logic [ROOT_W-1:0] rem;
    logic [QUOT_W-1:0] quot;
  } dlane_t;

  typedef struct packed {
    tag_t              tag;
    logic [ROOT_W-1:0] den;
    dlane_t [3:0]      lane;
  } div_stage_t;

  // One quotient bit per lane.
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t        n;
    logic [ROOT_W:0]   rsh;
    n = s;
    for (int i = 0; i < 4; i++) begin
      rsh = {s.lane[i].rem, s.lane[i].low[QUOT_W-1]};
      if (rsh >= {1'b0, s.den}) begin
        n.lane[i].rem  = ROOT_W'(rsh - {1'b0, s.den});
        n.lane[i].quot = {s.lane[i].quot[QUOT_W-2:0], 1'b1};
      end else begin
        n.lane[i].rem  = rsh[ROOT_W-1:0];
        n.lane[i].quot = {s.lane[i].quot[QUOT_W-2:0], 1'b0};
      end
      n.lane[i].low = s.lane[i].low << 1;
    end
    return n;
  endfunction

  div_stage_t prep;
  div_stage_t prep_next;
  div_stage_t nxt [DIV_STAGES];
  div_stage_t st  [DIV_STAGES];

  // Numerator is the magnitude in fraction units plus half the divisor for rounding.
  always_comb begin
    logic [ROOT_W-1:0] den;
    logic [NUM_W-1:0]  num;
    den = (root == '0) ? ROOT_W'(1) : root;
    prep_next.tag = in_tag;
    prep_next.den = den;
    for (int i = 0; i < 4; i++) begin
      num = (NUM_W'(in_tag.lane[i].mag) << FRAC_BITS) + NUM_W'(den >> 1);
      prep_next.lane[i].rem  = ROOT_W'(num[NUM_W-1:QUOT_W]);
      prep_next.lane[i].low  = num[QUOT_W-1:0];
      prep_next.lane[i].quot = '0;
    end
  end

  always_comb begin
    nxt[0] = div_step(prep);
    for (int s = 1; s < DIV_STAGES; s++) begin
      nxt[s] = div_step(st[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep.tag.valid <= 1'b0;
      for (int s = 0; s < DIV_STAGES; s++) begin
        st[s].tag.valid <= 1'b0;
      end
    end else if (en) begin
      prep <= prep_next;
      for (int s = 0; s < DIV_STAGES; s++) begin
        st[s] <= nxt[s];
      end
    end
  end

  assign out_tag = st[DIV_STAGES-1].tag;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quot[i] = st[DIV_STAGES-1].lane[i].quot;
    end
  end

endmodule
